// ===== design/cpwc_pkg.sv =====
// Shared constants, types and helpers for the power-weighted centroid core.
// No dependencies; used by every module of the block.
`default_nettype none

package cpwc_pkg;

    // Energy word width and derived datapath widths
    localparam int ENERGY_BITS = 16;
    localparam int LEAD_BITS   = 4;    // leading-one position of an energy
    localparam int MANT_BITS   = 31;   // Q30 mantissa, value in [1,2)
    localparam int FRAC_BITS   = 16;   // log2 fraction bits
    localparam int LOG_BITS    = LEAD_BITS + FRAC_BITS;
    localparam int EXP_BITS    = 19;   // exponent y = 0.395*log2(e), Q16
    localparam int ACC_BITS    = 17;   // Q16 power accumulator, below 2.0
    localparam int WEIGHT_BITS = 24;
    localparam int DEN_BITS    = WEIGHT_BITS + 2;
    localparam int NUM_BITS    = 41;   // signed weighted position sums
    localparam int MAG_BITS    = 39;
    localparam int SCALE_BITS  = 17;
    localparam int REM_BITS    = 41;   // dividend after the 2^16 prescale
    localparam int QUOT_BITS   = 15;
    localparam int COORD_BITS  = 15;
    localparam int COUNT_BITS  = 8;

    // Pipeline depths
    localparam int WEIGHT_STAGES = 1 + FRAC_BITS + 1 + 8 + 1;
    localparam int DIV_STAGES    = QUOT_BITS;

    // Arithmetic constants (Q16 unless noted)
    localparam logic [14:0] ALPHA_Q16  = 15'd25887;
    localparam logic [15:0] LN2_Q16    = 16'd45426;
    localparam int          SCALE_BASE = 124099;
    localparam logic [ACC_BITS-1:0] ACC_ONE = ACC_BITS'(65536);

    // Q16 constants 2^(2^-i), i = 1..8
    localparam logic [16:0] ROOT_Q16 [8] = '{
        17'd92682, 17'd77936, 17'd71468, 17'd68438,
        17'd66971, 17'd66250, 17'd65892, 17'd65714
    };

    // Tower positions, Q12 cm
    typedef logic signed [14:0] pos_t;
    localparam pos_t POS_X [4] = '{-15'sd7168, 15'sd7168, -15'sd7168, 15'sd7168};
    localparam pos_t POS_Y [4] = '{-15'sd7168, -15'sd7045, 15'sd7168, 15'sd7168};

    localparam logic signed [COORD_BITS-1:0] OUT_MAX = 15'sd16383;
    localparam logic signed [COORD_BITS-1:0] OUT_MIN = -15'sd16384;

    // Result word handed to the output buffer
    typedef struct packed {
        logic [COORD_BITS-1:0] centroid_x;
        logic [COORD_BITS-1:0] centroid_y;
        logic                  centroid_valid;
    } result_t;

    // Control carried beside the divider
    typedef struct packed {
        logic valid;
        logic neg_x;
        logic neg_y;
        logic nonzero;
    } div_ctl_t;

    // Rounded magnitude plus sign to a saturated signed coordinate
    function automatic logic [COORD_BITS-1:0] sat_coord(
        input logic [QUOT_BITS-1:0] q,
        input logic                 neg
    );
        logic [COORD_BITS-1:0] res;
        if (neg) begin
            if ({1'b0, q} > 16'd16384) res = OUT_MIN;
            else res = COORD_BITS'(-{1'b0, q});
        end else begin
            if (q > QUOT_BITS'(OUT_MAX)) res = OUT_MAX;
            else res = q;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== design/cpwc_weight.sv =====
// Per-tower weight pipeline: w = e^0.395 via log2 by repeated squaring,
// scaling, and 2^y by a root product chain. Uses cpwc_pkg.
`default_nettype none

module cpwc_weight (
    input  wire logic                              aclk,
    input  wire logic                              en,
    input  wire logic [cpwc_pkg::ENERGY_BITS-1:0]  energy,
    output logic      [cpwc_pkg::WEIGHT_BITS-1:0]  weight
);

    localparam int NSQ = cpwc_pkg::FRAC_BITS;

    logic [cpwc_pkg::MANT_BITS-1:0] x_reg    [0:NSQ];
    logic [cpwc_pkg::FRAC_BITS-1:0] frac_reg [0:NSQ];
    logic [cpwc_pkg::LEAD_BITS-1:0] p_reg    [0:NSQ];
    logic                           z_reg    [0:NSQ+9];

    logic [cpwc_pkg::EXP_BITS-1:0]  y_reg    [0:8];
    logic [cpwc_pkg::ACC_BITS-1:0]  acc_reg  [0:8];
    logic [7:0]                     t_reg    [1:8];
    logic [cpwc_pkg::WEIGHT_BITS-1:0] w_reg;

    // Leading-one search and normalization
    logic [cpwc_pkg::LEAD_BITS-1:0] lead;
    logic [cpwc_pkg::MANT_BITS-1:0] norm;
    always_comb begin
        lead = '0;
        for (int i = 0; i < cpwc_pkg::ENERGY_BITS; i++) begin
            if (energy[i]) lead = cpwc_pkg::LEAD_BITS'(i);
        end
        norm = cpwc_pkg::MANT_BITS'({15'd0, energy} << (5'd30 - {1'b0, lead}));
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0]    <= norm;
            frac_reg[0] <= '0;
            p_reg[0]    <= lead;
            z_reg[0]    <= (energy == '0);
        end
    end

    // One fraction bit of log2 per squaring stage
    for (genvar gi = 0; gi < NSQ; gi++) begin : g_sq
        logic [61:0] sq;
        assign sq = 62'(x_reg[gi]) * 62'(x_reg[gi]);
        always_ff @(posedge aclk) begin
            if (en) begin
                x_reg[gi+1]    <= sq[61] ? sq[61:31] : sq[60:30];
                frac_reg[gi+1] <= {frac_reg[gi][cpwc_pkg::FRAC_BITS-2:0], sq[61]};
                p_reg[gi+1]    <= p_reg[gi];
                z_reg[gi+1]    <= z_reg[gi];
            end
        end
    end

    // y = round(log2(e) * 0.395), Q16
    logic [34:0] yprod;
    assign yprod = 35'({p_reg[NSQ], frac_reg[NSQ]}) * 35'(cpwc_pkg::ALPHA_Q16) + 35'(32768);
    always_ff @(posedge aclk) begin
        if (en) begin
            y_reg[0]     <= yprod[34:16];
            acc_reg[0]   <= cpwc_pkg::ACC_ONE;
            z_reg[NSQ+1] <= z_reg[NSQ];
        end
    end

    // Root chain on the top eight fraction bits of y
    for (genvar gr = 0; gr < 8; gr++) begin : g_root
        logic [33:0] rprod;
        assign rprod = 34'(acc_reg[gr]) * 34'(cpwc_pkg::ROOT_Q16[gr]) + 34'(32768);
        always_ff @(posedge aclk) begin
            if (en) begin
                acc_reg[gr+1]     <= y_reg[gr][15-gr] ? rprod[32:16] : acc_reg[gr];
                y_reg[gr+1]       <= y_reg[gr];
                z_reg[NSQ+2+gr]   <= z_reg[NSQ+1+gr];
            end
        end
        if (gr == 0) begin : g_t
            // linear term for the low eight bits: t = g * ln2
            logic [24:0] tprod;
            assign tprod = 25'(y_reg[0][7:0]) * 25'(cpwc_pkg::LN2_Q16) + 25'(32768);
            always_ff @(posedge aclk) begin
                if (en) t_reg[1] <= tprod[23:16];
            end
        end else begin : g_tc
            always_ff @(posedge aclk) begin
                if (en) t_reg[gr+1] <= t_reg[gr];
            end
        end
    end

    // acc * (1 + t), then shift by the integer part of y
    logic [25:0] lprod;
    logic [17:0] acc_lin;
    assign lprod   = 26'(acc_reg[8]) * 26'(t_reg[8]) + 26'(32768);
    assign acc_lin = 18'(acc_reg[8]) + 18'(lprod[25:16]);
    always_ff @(posedge aclk) begin
        if (en) begin
            w_reg <= z_reg[NSQ+9] ? '0
                   : cpwc_pkg::WEIGHT_BITS'(24'(acc_lin) << y_reg[8][18:16]);
        end
    end

    assign weight = w_reg;

endmodule

`default_nettype wire

// ===== design/cpwc_divider.sv =====
// Pipelined restoring divider, one quotient bit per stage.
// Uses cpwc_pkg widths; quotient assumed to fit in QUOT_BITS.
`default_nettype none

module cpwc_divider (
    input  wire logic                             aclk,
    input  wire logic                             en,
    input  wire logic [cpwc_pkg::REM_BITS-1:0]    num,
    input  wire logic [cpwc_pkg::DEN_BITS-1:0]    den,
    output logic      [cpwc_pkg::QUOT_BITS-1:0]   quot
);

    localparam int NS = cpwc_pkg::QUOT_BITS;

    logic [cpwc_pkg::REM_BITS-1:0]  rem_reg [1:NS-1];
    logic [cpwc_pkg::DEN_BITS-1:0]  den_reg [1:NS-1];
    logic [cpwc_pkg::QUOT_BITS-1:0] q_reg   [1:NS];

    for (genvar s = 0; s < NS; s++) begin : g_stage
        logic [cpwc_pkg::REM_BITS-1:0]  r_in;
        logic [cpwc_pkg::DEN_BITS-1:0]  d_in;
        logic [cpwc_pkg::QUOT_BITS-1:0] q_in;
        logic [cpwc_pkg::REM_BITS-1:0]  dsh;
        logic                           ge;

        if (s == 0) begin : g_first
            assign r_in = num;
            assign d_in = den;
            assign q_in = '0;
        end else begin : g_next
            assign r_in = rem_reg[s];
            assign d_in = den_reg[s];
            assign q_in = q_reg[s];
        end

        // trial subtract of the shifted divisor
        assign dsh = cpwc_pkg::REM_BITS'(d_in) << (NS - 1 - s);
        assign ge  = (r_in >= dsh);

        always_ff @(posedge aclk) begin
            if (en) begin
                q_reg[s+1] <= {q_in[NS-1:1], 1'b0} | (q_in & cpwc_pkg::QUOT_BITS'(1))
                            | (ge ? cpwc_pkg::QUOT_BITS'(1) << (NS - 1 - s) : '0);
            end
        end

        if (s < NS - 1) begin : g_carry
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[s+1] <= ge ? r_in - dsh : r_in;
                    den_reg[s+1] <= d_in;
                end
            end
        end
    end

    assign quot = q_reg[NS];

endmodule

`default_nettype wire

// ===== design/cpwc_out_buf.sv =====
// Output register plus skid entry for the result stream.
// Uses cpwc_pkg::result_t.
`default_nettype none

module cpwc_out_buf (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               push,
    input  wire cpwc_pkg::result_t  push_data,
    output logic                    can_take,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output cpwc_pkg::result_t       m_data
);

    logic              m_valid_reg;
    logic              skid_valid_reg;
    cpwc_pkg::result_t m_data_reg;
    cpwc_pkg::result_t skid_data_reg;

    // Control: the skid entry fills only while the output is stalled
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!m_valid_reg || m_ready) begin
            m_valid_reg    <= skid_valid_reg || push;
            skid_valid_reg <= 1'b0;
        end else if (push) begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (!m_valid_reg || m_ready) begin
            m_data_reg <= skid_valid_reg ? skid_data_reg : push_data;
        end else if (push) begin
            skid_data_reg <= push_data;
        end
    end

    assign can_take = !skid_valid_reg;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

endmodule

`default_nettype wire

// ===== design/calorimeter_power_weighted_centroid_core.sv =====
// Power-weighted 2x2 tower centroid. From request accept to m_tvalid a result
// passes 27 weight stages, 4 sum/scale stages, 15 divider stages, saturate and the
// output register. Throughput: one request per cycle; the whole pipeline
// advances together and holds while the output skid entry is full.
// Reset (aresetn low, synchronous) clears all valid bits; payload is not reset.
// Uses cpwc_pkg, cpwc_weight, cpwc_divider, cpwc_out_buf.
`default_nettype none

module calorimeter_power_weighted_centroid_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // tower_energy_a[15:0], tower_energy_b[31:16], tower_energy_c[47:32],
    // tower_energy_d[63:48], spectator_count[71:64]
    input  wire logic [71:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // centroid_x[14:0], centroid_y[29:15], zero[31:30]
    output logic [31:0]      m_tdata,
    // centroid_valid[0]
    output logic [0:0]       m_tuser
);

    localparam int WS = cpwc_pkg::WEIGHT_STAGES;
    localparam int DS = cpwc_pkg::DIV_STAGES;

    logic en;
    logic can_take;
    assign en       = can_take;
    // no request is taken while reset is held
    assign s_tready = en && aresetn;

    // Scale c(n) table, Q16, worked out at elaboration
    logic [cpwc_pkg::SCALE_BITS-1:0] scale_tbl [256];
    for (genvar gn = 0; gn < 256; gn++) begin : g_scale
        localparam longint D    = 10000 * gn + 7179;
        localparam longint TERM = (64'd7126 * 64'd65536 * 64'd2 + D) / (2 * D);
        assign scale_tbl[gn] = cpwc_pkg::SCALE_BITS'(cpwc_pkg::SCALE_BASE - TERM);
    end

    // Weight pipelines, one per tower
    logic [cpwc_pkg::WEIGHT_BITS-1:0] w [4];
    for (genvar gt = 0; gt < 4; gt++) begin : g_tower
        cpwc_weight u_weight (
            .aclk   (aclk),
            .en     (en),
            .energy (s_tdata[gt*16 +: cpwc_pkg::ENERGY_BITS]),
            .weight (w[gt])
        );
    end

    // Valid and scale travel beside the weight pipelines
    logic                            wv_reg [0:WS-1];
    logic [cpwc_pkg::SCALE_BITS-1:0] wc_reg [0:WS-1];
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < WS; i++) wv_reg[i] <= 1'b0;
        end else if (en) begin
            wv_reg[0] <= s_tvalid;
            for (int i = 1; i < WS; i++) wv_reg[i] <= wv_reg[i-1];
        end
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            wc_reg[0] <= scale_tbl[s_tdata[64 +: cpwc_pkg::COUNT_BITS]];
            for (int i = 1; i < WS; i++) wc_reg[i] <= wc_reg[i-1];
        end
    end

    // Stage A: position products and weight sum
    logic signed [38:0] px_c [4];
    logic signed [38:0] py_c [4];
    for (genvar gp = 0; gp < 4; gp++) begin : g_prod
        assign px_c[gp] = cpwc_pkg::POS_X[gp] * $signed({1'b0, w[gp]});
        assign py_c[gp] = cpwc_pkg::POS_Y[gp] * $signed({1'b0, w[gp]});
    end

    logic signed [38:0]              px_reg [4];
    logic signed [38:0]              py_reg [4];
    logic [cpwc_pkg::DEN_BITS-1:0]   a_den_reg;
    logic [cpwc_pkg::SCALE_BITS-1:0] a_scale_reg;
    logic                            a_valid_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 4; i++) begin
                px_reg[i] <= px_c[i];
                py_reg[i] <= py_c[i];
            end
            a_den_reg   <= cpwc_pkg::DEN_BITS'(w[0]) + cpwc_pkg::DEN_BITS'(w[1])
                         + cpwc_pkg::DEN_BITS'(w[2]) + cpwc_pkg::DEN_BITS'(w[3]);
            a_scale_reg <= wc_reg[WS-1];
        end
    end

    // Stage B: signed position sums
    logic signed [cpwc_pkg::NUM_BITS-1:0] b_nx_reg;
    logic signed [cpwc_pkg::NUM_BITS-1:0] b_ny_reg;
    logic [cpwc_pkg::DEN_BITS-1:0]        b_den_reg;
    logic [cpwc_pkg::SCALE_BITS-1:0]      b_scale_reg;
    logic                                 b_valid_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            b_nx_reg <= cpwc_pkg::NUM_BITS'(px_reg[0]) + cpwc_pkg::NUM_BITS'(px_reg[1])
                      + cpwc_pkg::NUM_BITS'(px_reg[2]) + cpwc_pkg::NUM_BITS'(px_reg[3]);
            b_ny_reg <= cpwc_pkg::NUM_BITS'(py_reg[0]) + cpwc_pkg::NUM_BITS'(py_reg[1])
                      + cpwc_pkg::NUM_BITS'(py_reg[2]) + cpwc_pkg::NUM_BITS'(py_reg[3]);
            b_den_reg   <= a_den_reg;
            b_scale_reg <= a_scale_reg;
        end
    end

    // Stage C: magnitudes split in two halves, each times the scale
    logic [cpwc_pkg::NUM_BITS-1:0] mag_x_full;
    logic [cpwc_pkg::NUM_BITS-1:0] mag_y_full;
    logic [cpwc_pkg::MAG_BITS-1:0] mag_x;
    logic [cpwc_pkg::MAG_BITS-1:0] mag_y;
    assign mag_x_full = b_nx_reg[cpwc_pkg::NUM_BITS-1] ? -b_nx_reg : b_nx_reg;
    assign mag_y_full = b_ny_reg[cpwc_pkg::NUM_BITS-1] ? -b_ny_reg : b_ny_reg;
    assign mag_x      = mag_x_full[cpwc_pkg::MAG_BITS-1:0];
    assign mag_y      = mag_y_full[cpwc_pkg::MAG_BITS-1:0];

    logic [36:0]                   c_xlo_reg, c_ylo_reg;
    logic [35:0]                   c_xhi_reg, c_yhi_reg;
    logic [cpwc_pkg::DEN_BITS-1:0] c_den_reg;
    cpwc_pkg::div_ctl_t            c_ctl_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_ctl_reg.valid <= 1'b0;
        end else if (en) begin
            c_ctl_reg.valid <= b_valid_reg;
        end
        if (en) begin
            c_xlo_reg <= 37'(mag_x[19:0]) * 37'(b_scale_reg);
            c_xhi_reg <= 36'(mag_x[38:20]) * 36'(b_scale_reg);
            c_ylo_reg <= 37'(mag_y[19:0]) * 37'(b_scale_reg);
            c_yhi_reg <= 36'(mag_y[38:20]) * 36'(b_scale_reg);
            c_den_reg <= b_den_reg;
            c_ctl_reg.neg_x   <= b_nx_reg[cpwc_pkg::NUM_BITS-1];
            c_ctl_reg.neg_y   <= b_ny_reg[cpwc_pkg::NUM_BITS-1];
            c_ctl_reg.nonzero <= (b_den_reg != '0);
        end
    end

    // Stage D: add halves and the rounding half divisor, drop 16 bits
    logic [56:0] big_x, big_y;
    assign big_x = (57'(c_xhi_reg) << 20) + 57'(c_xlo_reg) + (57'(c_den_reg) << 15);
    assign big_y = (57'(c_yhi_reg) << 20) + 57'(c_ylo_reg) + (57'(c_den_reg) << 15);

    logic [cpwc_pkg::REM_BITS-1:0] d_nx_reg, d_ny_reg;
    logic [cpwc_pkg::DEN_BITS-1:0] d_den_reg;
    cpwc_pkg::div_ctl_t            d_ctl_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_ctl_reg.valid <= 1'b0;
        end else if (en) begin
            d_ctl_reg.valid <= c_ctl_reg.valid;
        end
        if (en) begin
            d_nx_reg  <= big_x[56:16];
            d_ny_reg  <= big_y[56:16];
            d_den_reg <= c_den_reg;
            d_ctl_reg.neg_x   <= c_ctl_reg.neg_x;
            d_ctl_reg.neg_y   <= c_ctl_reg.neg_y;
            d_ctl_reg.nonzero <= c_ctl_reg.nonzero;
        end
    end

    // Valid bits of stages A and B
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg     <= 1'b0;
            b_valid_reg     <= 1'b0;
        end else if (en) begin
            a_valid_reg     <= wv_reg[WS-1];
            b_valid_reg     <= a_valid_reg;
        end
    end

    // Dividers
    logic [cpwc_pkg::QUOT_BITS-1:0] q_x, q_y;
    cpwc_divider u_div_x (
        .aclk (aclk), .en (en), .num (d_nx_reg), .den (d_den_reg), .quot (q_x)
    );
    cpwc_divider u_div_y (
        .aclk (aclk), .en (en), .num (d_ny_reg), .den (d_den_reg), .quot (q_y)
    );

    // Control beside the dividers; only the valid bits are reset
    cpwc_pkg::div_ctl_t dctl_reg [1:DS];
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 1; i <= DS; i++) dctl_reg[i].valid <= 1'b0;
        end else if (en) begin
            dctl_reg[1].valid <= d_ctl_reg.valid;
            for (int i = 2; i <= DS; i++) dctl_reg[i].valid <= dctl_reg[i-1].valid;
        end
        if (en) begin
            dctl_reg[1].neg_x   <= d_ctl_reg.neg_x;
            dctl_reg[1].neg_y   <= d_ctl_reg.neg_y;
            dctl_reg[1].nonzero <= d_ctl_reg.nonzero;
            for (int i = 2; i <= DS; i++) begin
                dctl_reg[i].neg_x   <= dctl_reg[i-1].neg_x;
                dctl_reg[i].neg_y   <= dctl_reg[i-1].neg_y;
                dctl_reg[i].nonzero <= dctl_reg[i-1].nonzero;
            end
        end
    end

    // Stage F: sign, saturation, empty-face case
    cpwc_pkg::result_t f_res_reg;
    logic              f_valid_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) f_valid_reg <= 1'b0;
        else if (en)  f_valid_reg <= dctl_reg[DS].valid;
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            if (dctl_reg[DS].nonzero) begin
                f_res_reg.centroid_x     <= cpwc_pkg::sat_coord(q_x, dctl_reg[DS].neg_x);
                f_res_reg.centroid_y     <= cpwc_pkg::sat_coord(q_y, dctl_reg[DS].neg_y);
                f_res_reg.centroid_valid <= 1'b1;
            end else begin
                f_res_reg <= '0;
            end
        end
    end

    // Output register and skid entry
    cpwc_pkg::result_t out_res;
    cpwc_out_buf u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (en && f_valid_reg),
        .push_data (f_res_reg),
        .can_take  (can_take),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_data    (out_res)
    );

    assign m_tdata = {2'b00, out_res.centroid_y, out_res.centroid_x};
    assign m_tuser = out_res.centroid_valid;

    // A full skid entry only exists behind a valid output result
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        !can_take |-> m_tvalid)
        else $error("skid entry full without an output result");

    // An empty face gives zero coordinates
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == 32'd0))
        else $error("empty face with nonzero coordinates");

    // Centroid stays within the scaled tower span
    a_span: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[14:0]) <= 15'sd13600
                   && $signed(m_tdata[14:0]) >= -15'sd13600
                   && $signed(m_tdata[29:15]) <= 15'sd13600
                   && $signed(m_tdata[29:15]) >= -15'sd13600))
        else $error("centroid outside tower span");

endmodule

`default_nettype wire

// ===== test/calorimeter_power_weighted_centroid_core_tb.sv =====
// Testbench for the power-weighted 2x2 tower centroid core: drives random and
// directed requests, predicts each result in fixed point and checks in order.
// Depends on calorimeter_power_weighted_centroid_core.
`timescale 1ns / 1ps

module calorimeter_power_weighted_centroid_core_tb;

    typedef struct packed {
        logic [14:0] cx;
        logic [14:0] cy;
        logic        cvalid;
    } centroid_t;

    int errors = 0;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // Energy weight E^0.395 in fixed point
    function automatic longint unsigned tower_weight(input longint unsigned e);
        longint unsigned roots [8] = '{92682, 77936, 71468, 68438, 66971, 66250,
                                       65892, 65714};
        longint unsigned x, frac, lg, y, k, fhi, flo, acc, t;
        int p;
        if (e == 0) return 0;
        p = 0;
        frac = 0;
        for (int i = 0; i < 32; i++) if (e[i]) p = i;
        x = e << (30 - p);
        for (int i = 0; i < 16; i++) begin
            x = (x * x) >> 30;
            if (x >= (64'd1 << 31)) begin
                x = x >> 1;
                frac |= 64'd1 << (15 - i);
            end
        end
        lg = (longint'(p) << 16) | frac;
        y = (lg * 25887 + 32768) >> 16;
        k = y >> 16;
        fhi = (y >> 8) & 8'hFF;
        flo = y & 8'hFF;
        acc = 64'd1 << 16;
        for (int i = 0; i < 8; i++)
            if (fhi[7 - i]) acc = (acc * roots[i] + 32768) >> 16;
        t = (flo * 45426 + 32768) >> 16;
        acc = acc + ((acc * t + 32768) >> 16);
        if (k > 15) k = 15;
        return acc << k;
    endfunction

    function automatic logic [14:0] scaled_coord(input longint num,
                                                 input longint unsigned den,
                                                 input longint unsigned c);
        longint unsigned mag, dd, q;
        longint v;
        mag = (num < 0) ? longint'(-num) : num;
        dd = den << 16;
        q = (mag * c + dd / 2) / dd;
        if (num < 0) v = (q > 16384) ? -16384 : -longint'(q);
        else v = (q > 16383) ? 16383 : longint'(q);
        return v[14:0];
    endfunction

    function automatic centroid_t predict_centroid(input logic [71:0] req);
        longint px [4] = '{-7168, 7168, -7168, 7168};
        longint py [4] = '{-7168, -7045, 7168, 7168};
        longint nx, ny;
        longint unsigned den, w, d, c, n;
        centroid_t r;
        nx = 0;
        ny = 0;
        den = 0;
        for (int i = 0; i < 4; i++) begin
            w = tower_weight(req[16*i +: 16]);
            nx += px[i] * longint'(w);
            ny += py[i] * longint'(w);
            den += w;
        end
        r = '0;
        if (den == 0) return r;
        n = req[71:64];
        d = 10000 * n + 7179;
        c = 124099 - (7126 * 65536 * 2 + d) / (2 * d);
        r.cx = scaled_coord(nx, den, c);
        r.cy = scaled_coord(ny, den, c);
        r.cvalid = 1'b1;
        return r;
    endfunction

    // Scoreboard of expected centroids
    class centroid_board;
        centroid_t pending [$];
        function void note_request(input logic [71:0] req);
            pending.push_back(predict_centroid(req));
        endfunction
        task check_result(input logic [31:0] data, input logic usr);
            centroid_t want;
            if (pending.size() == 0) begin
                report_mismatch("unexpected result", data, 0);
                return;
            end
            want = pending.pop_front();
            if (data[14:0] !== want.cx)
                report_mismatch("centroid_x", $signed(data[14:0]), $signed(want.cx));
            if (data[29:15] !== want.cy)
                report_mismatch("centroid_y", $signed(data[29:15]), $signed(want.cy));
            if (data[31:30] !== 2'b00) report_mismatch("pad bits", data[31:30], 0);
            if (usr !== want.cvalid) report_mismatch("centroid_valid", usr, want.cvalid);
        endtask
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [0:0]  m_tuser;
    bit          quiet = 1'b0;
    centroid_board board = new();

    calorimeter_power_weighted_centroid_core u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Monitor accepted requests and results
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) board.note_request(s_tdata);
        if (aresetn && m_tvalid && m_tready) board.check_result(m_tdata, m_tuser[0]);
    end

    // Result-side stall bursts
    initial begin
        int n;
        @(posedge aclk iff aresetn);
        forever begin
            n = $urandom_range(1, 10);
            if (!quiet && $urandom_range(0, 2) == 0) begin
                m_tready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat (n) @(posedge aclk);
        end
    end

    // Random energy with a wide spread of magnitudes
    function automatic logic [15:0] rand_energy();
        case ($urandom_range(0, 5))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(0, 255));
            3: return 16'(1 << $urandom_range(0, 15));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_request(input logic [71:0] req);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= req;
        @(posedge aclk iff s_tready);
    endtask

    initial begin
        logic [71:0] req;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // Directed: empty face, extremes, single towers, count extremes
        send_request('0);
        send_request({8'd0, {4{16'hFFFF}}});
        send_request({8'd255, {4{16'hFFFF}}});
        send_request({8'd255, 64'h0});
        for (int i = 0; i < 4; i++) begin
            req = '0;
            req[16*i +: 16] = 16'hFFFF;
            req[71:64] = 8'd255;
            send_request(req);
            req[16*i +: 16] = 16'h0001;
            req[71:64] = 8'd0;
            send_request(req);
        end
        send_request({8'hAA, 64'h5555_AAAA_5555_AAAA});
        send_request({8'h55, 64'hAAAA_5555_AAAA_5555});
        send_request({8'd1, 16'd0, 16'd0, 16'd300, 16'd7});
        // Sender holds off until the pipeline drains
        s_tvalid <= 1'b0;
        wait (board.pending.size() == 0);
        @(posedge aclk);
        for (int i = 0; i < 1000; i++) begin
            if (i == 850) quiet = 1'b1;
            req = {8'($urandom), rand_energy(), rand_energy(), rand_energy(), rand_energy()};
            if ($urandom_range(0, 3) == 0) req[71:64] = $urandom_range(0, 3) == 0 ? 8'd0 : 8'd255;
            send_request(req);
        end
        s_tvalid <= 1'b0;
        wait (board.pending.size() == 0);
        repeat (60) @(posedge aclk);
        if (errors == 0 && board.pending.size() == 0) $display("end of test: clean");
        else $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #2ms;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== files.f =====
design/cpwc_pkg.sv
design/cpwc_weight.sv
design/cpwc_divider.sv
design/cpwc_out_buf.sv
design/calorimeter_power_weighted_centroid_core.sv
test/calorimeter_power_weighted_centroid_core_tb.sv
